@@ hw/rtl/balance_position_pid_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the balance/position controller
// Concurrent checks compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BALANCE_POSITION_PID_MACROS_SVH
`define BALANCE_POSITION_PID_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define BPP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bpp assertion failed");
// Check that a condition in one cycle implies another in the next cycle
`define BPP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bpp assertion failed");
`else
`define BPP_ASSERT(name, clk, rstn, prop)
`define BPP_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/bpp_pkg.sv @@
// ---------------------------------------------------------------------------
// bpp_pkg
// Widths, reset values, register map and stage types of the controller.
// ---------------------------------------------------------------------------
package bpp_pkg;

  // Field widths
  localparam int PITCH_W  = 17;
  localparam int COUNT_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int WIN_W    = 16;
  localparam int LIMIT_W  = 12;
  localparam int DRIVE_W  = 13;
  localparam int PERR_W   = 18;
  localparam int AERR_W   = 18;
  localparam int INTEG_W  = 32;

  // Configuration port
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;

  // Fraction bits dropped from each loop sum
  localparam int BAL_FRAC = 16;
  localparam int POS_FRAC = 8;

  // Derived datapath widths
  localparam int DERR_W   = AERR_W + 1;
  localparam int DPERR_W  = PERR_W + 1;
  localparam int SGAIN_W  = GAIN_W + 1;
  localparam int PBP_W    = SGAIN_W + AERR_W;
  localparam int PBI_W    = SGAIN_W + INTEG_W;
  localparam int PBD_W    = SGAIN_W + DERR_W;
  localparam int PPP_W    = SGAIN_W + PERR_W;
  localparam int PPD_W    = SGAIN_W + DPERR_W;
  localparam int BSUM_W   = PBI_W + 1;
  localparam int PSUM_W   = PPD_W + 1;
  localparam int BAL_W    = BSUM_W - BAL_FRAC;
  localparam int POS_W    = PSUM_W - POS_FRAC;
  localparam int DRV_W    = BAL_W + 1;

  // Register reset values
  localparam logic signed [PITCH_W-1:0] RST_TARGET_PITCH = '0;
  localparam logic [GAIN_W-1:0]  RST_KP_BALANCE    = 16'd5120;
  localparam logic [GAIN_W-1:0]  RST_KI_BALANCE    = 16'd0;
  localparam logic [GAIN_W-1:0]  RST_KD_BALANCE    = 16'd1280;
  localparam logic [GAIN_W-1:0]  RST_KP_POSITION   = 16'd205;
  localparam logic [GAIN_W-1:0]  RST_KD_POSITION   = 16'd26;
  localparam logic [WIN_W-1:0]   RST_INT_WINDOW    = 16'd5120;
  localparam logic [LIMIT_W-1:0] RST_OUTPUT_LIMIT  = 12'd1000;

  // Register map, word index
  typedef enum logic [ADDR_W-3:0] {
    REG_TARGET_PITCH = 3'd0,
    REG_KP_BALANCE   = 3'd1,
    REG_KI_BALANCE   = 3'd2,
    REG_KD_BALANCE   = 3'd3,
    REG_KP_POSITION  = 3'd4,
    REG_KD_POSITION  = 3'd5,
    REG_INT_WINDOW   = 3'd6,
    REG_OUTPUT_LIMIT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [PITCH_W-1:0] target_pitch;
    logic [GAIN_W-1:0]         kp_balance;
    logic [GAIN_W-1:0]         ki_balance;
    logic [GAIN_W-1:0]         kd_balance;
    logic [GAIN_W-1:0]         kp_position;
    logic [GAIN_W-1:0]         kd_position;
    logic [WIN_W-1:0]          integral_window;
    logic [LIMIT_W-1:0]        output_limit;
  } cfg_t;

  // Errors and integral of one transaction
  typedef struct packed {
    logic signed [AERR_W-1:0]  aerr;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERR_W-1:0]  daerr;
    logic signed [PERR_W-1:0]  perr;
    logic signed [DPERR_W-1:0] dperr;
  } front_t;

  // Gain products of one transaction
  typedef struct packed {
    logic signed [PBP_W-1:0]  bal_p;
    logic signed [PBI_W-1:0]  bal_i;
    logic signed [PBD_W-1:0]  bal_d;
    logic signed [PPP_W-1:0]  pos_p;
    logic signed [PPD_W-1:0]  pos_d;
    logic signed [PERR_W-1:0] perr;
  } prod_t;

endpackage

@@ hw/rtl/bpp_meas_if.sv @@
// ---------------------------------------------------------------------------
// bpp_meas_if
// Measurement channel: pitch angle and both wheel encoder counts.
// ---------------------------------------------------------------------------
interface bpp_meas_if
  import bpp_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [COUNT_W-1:0] left_count;
  logic signed [COUNT_W-1:0] right_count;

  modport source (
    output valid, pitch_angle, left_count, right_count,
    input  ready
  );

  modport sink (
    input  valid, pitch_angle, left_count, right_count,
    output ready
  );
endinterface

@@ hw/rtl/bpp_drive_if.sv @@
// ---------------------------------------------------------------------------
// bpp_drive_if
// Drive channel: clamped motor drive, position error and clamp flag.
// ---------------------------------------------------------------------------
interface bpp_drive_if
  import bpp_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] motor_drive;
  logic signed [PERR_W-1:0]  position_error;
  logic                      clamped;

  modport source (
    output valid, motor_drive, position_error, clamped,
    input  ready
  );

  modport sink (
    input  valid, motor_drive, position_error, clamped,
    output ready
  );
endinterface

@@ hw/rtl/balance_position_pid.sv @@
// ---------------------------------------------------------------------------
// balance_position_pid
// Balance PID and position PD controller, combined into a clamped drive.
// ---------------------------------------------------------------------------
// Usage:
//   meas_i carries one control period per transaction: pitch angle (Q8.8
//   degrees) and the left and right encoder counts. drive_o returns one
//   transaction per measurement: clamped motor drive, position error and
//   the clamp flag, in the order the measurements were taken.
//   Registers sit on the APB port at byte address 4*index; write them only
//   while no measurement is in flight. pready is tied high.
// Timing:
//   Four register stages (errors and integral, gain products, loop sums,
//   clamped output); a measurement passes through them in that order.
//   One measurement is accepted every cycle while drive_o.ready holds;
//   the integral recurrence closes within the error stage.
// Reset:
//   Clears the integral, the previous errors and all stage valids, and
//   loads the register reset values.
// Stall:
//   A held result keeps drive_o stable; stages behind it fill their empty
//   slots, then meas_i.ready drops until drive_o.ready returns.
// ---------------------------------------------------------------------------
module balance_position_pid
  import bpp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  bpp_meas_if.sink          meas_i,
  bpp_drive_if.source       drive_o
);

  cfg_t   cfg;
  logic   front_valid, front_ready;
  front_t front_data;
  logic   prod_valid, prod_ready;
  prod_t  prod_data;

  // Configuration registers
  bpp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Errors and integral
  bpp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .meas_i  (meas_i),
    .valid_o (front_valid),
    .ready_i (front_ready),
    .data_o  (front_data)
  );

  // Gain products
  bpp_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .data_i  (front_data),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  // Loop sums and clamped output
  bpp_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod_data),
    .drive_o (drive_o)
  );

endmodule

@@ hw/rtl/bpp_cfg.sv @@
// ---------------------------------------------------------------------------
// bpp_cfg
// APB register file holding target, gains, integration window and limit.
// ---------------------------------------------------------------------------
module bpp_cfg
  import bpp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  logic     wr;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_pitch    <= RST_TARGET_PITCH;
      cfg_q.kp_balance      <= RST_KP_BALANCE;
      cfg_q.ki_balance      <= RST_KI_BALANCE;
      cfg_q.kd_balance      <= RST_KD_BALANCE;
      cfg_q.kp_position     <= RST_KP_POSITION;
      cfg_q.kd_position     <= RST_KD_POSITION;
      cfg_q.integral_window <= RST_INT_WINDOW;
      cfg_q.output_limit    <= RST_OUTPUT_LIMIT;
    end else if (wr) begin
      unique case (idx)
        REG_TARGET_PITCH: cfg_q.target_pitch    <= $signed(pwdata[PITCH_W-1:0]);
        REG_KP_BALANCE:   cfg_q.kp_balance      <= pwdata[GAIN_W-1:0];
        REG_KI_BALANCE:   cfg_q.ki_balance      <= pwdata[GAIN_W-1:0];
        REG_KD_BALANCE:   cfg_q.kd_balance      <= pwdata[GAIN_W-1:0];
        REG_KP_POSITION:  cfg_q.kp_position     <= pwdata[GAIN_W-1:0];
        REG_KD_POSITION:  cfg_q.kd_position     <= pwdata[GAIN_W-1:0];
        REG_INT_WINDOW:   cfg_q.integral_window <= pwdata[WIN_W-1:0];
        REG_OUTPUT_LIMIT: cfg_q.output_limit    <= pwdata[LIMIT_W-1:0];
        default:          cfg_q.output_limit    <= cfg_q.output_limit;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_TARGET_PITCH: prdata = DATA_W'(cfg_q.target_pitch);
      REG_KP_BALANCE:   prdata = DATA_W'(cfg_q.kp_balance);
      REG_KI_BALANCE:   prdata = DATA_W'(cfg_q.ki_balance);
      REG_KD_BALANCE:   prdata = DATA_W'(cfg_q.kd_balance);
      REG_KP_POSITION:  prdata = DATA_W'(cfg_q.kp_position);
      REG_KD_POSITION:  prdata = DATA_W'(cfg_q.kd_position);
      REG_INT_WINDOW:   prdata = DATA_W'(cfg_q.integral_window);
      REG_OUTPUT_LIMIT: prdata = DATA_W'(cfg_q.output_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/bpp_front.sv @@
// ---------------------------------------------------------------------------
// bpp_front
// Error stage: angle and position errors, their differences and the
// windowed saturating integral. Owns the controller state.
// ---------------------------------------------------------------------------
`include "balance_position_pid_macros.svh"

module bpp_front
  import bpp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  bpp_meas_if.sink        meas_i,
  output logic            valid_o,
  input  logic            ready_i,
  output front_t          data_o
);

  localparam logic signed [INTEG_W:0] INT_MAX = (INTEG_W+1)'({1'b0, {(INTEG_W-1){1'b1}}});
  localparam logic signed [INTEG_W:0] INT_MIN = -INT_MAX - (INTEG_W+1)'(1);

  logic                      valid_q;
  front_t                    data_q;
  logic signed [AERR_W-1:0]  last_aerr_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [PERR_W-1:0]  last_perr_q;

  logic                      acc;
  logic                      in_win;
  logic signed [AERR_W-1:0]  aerr;
  logic [AERR_W-1:0]         amag;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] integ_d;
  logic signed [PERR_W-1:0]  csum;
  front_t                    data_d;

  assign meas_i.ready = !valid_q || ready_i;
  assign acc          = meas_i.valid && meas_i.ready;
  assign valid_o      = valid_q;
  assign data_o       = data_q;

  // Errors, window test and saturating integral
  always_comb begin
    aerr   = AERR_W'($signed(cfg_i.target_pitch)) - AERR_W'($signed(meas_i.pitch_angle));
    amag   = aerr[AERR_W-1] ? AERR_W'(-aerr) : AERR_W'(aerr);
    in_win = amag < AERR_W'(cfg_i.integral_window);
    isum   = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(aerr);
    if (!in_win) begin
      integ_d = '0;
    end else if (isum > INT_MAX) begin
      integ_d = INTEG_W'(INT_MAX);
    end else if (isum < INT_MIN) begin
      integ_d = INTEG_W'(INT_MIN);
    end else begin
      integ_d = INTEG_W'(isum);
    end
    csum         = PERR_W'($signed(meas_i.left_count)) + PERR_W'($signed(meas_i.right_count));
    data_d.aerr  = aerr;
    data_d.integ = integ_d;
    data_d.daerr = DERR_W'(aerr) - DERR_W'(last_aerr_q);
    data_d.perr  = -csum;
    data_d.dperr = DPERR_W'(-csum) - DPERR_W'(last_perr_q);
  end

  // Advance state and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      last_aerr_q <= '0;
      integ_q     <= '0;
      last_perr_q <= '0;
    end else begin
      if (meas_i.ready) begin
        valid_q <= meas_i.valid;
      end
      if (acc) begin
        last_aerr_q <= aerr;
        integ_q     <= integ_d;
        last_perr_q <= data_d.perr;
      end
    end
  end

  // Capture stage payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      data_q <= data_d;
    end
  end

  `BPP_ASSERT_NEXT(a_integ_clear, clk_i, rst_ni, acc && !in_win, integ_q == '0)
  `BPP_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !acc, $stable(integ_q) && $stable(last_aerr_q))

endmodule

@@ hw/rtl/bpp_mult.sv @@
// ---------------------------------------------------------------------------
// bpp_mult
// Product stage: the five gain multiplications of both loops.
// ---------------------------------------------------------------------------
module bpp_mult
  import bpp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   valid_i,
  output logic   ready_o,
  input  front_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output prod_t  data_o
);

  logic                      valid_q;
  prod_t                     data_q;
  prod_t                     data_d;
  logic signed [SGAIN_W-1:0] kpb, kib, kdb, kpp, kdp;
  logic signed [AERR_W-1:0]  aerr;
  logic signed [INTEG_W-1:0] integ;
  logic signed [DERR_W-1:0]  daerr;
  logic signed [PERR_W-1:0]  perr;
  logic signed [DPERR_W-1:0] dperr;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Multiply each error term by its gain
  always_comb begin
    kpb   = $signed({1'b0, cfg_i.kp_balance});
    kib   = $signed({1'b0, cfg_i.ki_balance});
    kdb   = $signed({1'b0, cfg_i.kd_balance});
    kpp   = $signed({1'b0, cfg_i.kp_position});
    kdp   = $signed({1'b0, cfg_i.kd_position});
    aerr  = $signed(data_i.aerr);
    integ = $signed(data_i.integ);
    daerr = $signed(data_i.daerr);
    perr  = $signed(data_i.perr);
    dperr = $signed(data_i.dperr);
    data_d.bal_p = PBP_W'(kpb) * PBP_W'(aerr);
    data_d.bal_i = PBI_W'(kib) * PBI_W'(integ);
    data_d.bal_d = PBD_W'(kdb) * PBD_W'(daerr);
    data_d.pos_p = PPP_W'(kpp) * PPP_W'(perr);
    data_d.pos_d = PPD_W'(kdp) * PPD_W'(dperr);
    data_d.perr  = perr;
  end

  // Advance stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture products
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

@@ hw/rtl/bpp_combine.sv @@
// ---------------------------------------------------------------------------
// bpp_combine
// Sum stage (loop sums truncated toward zero) and output stage (drive is
// position minus balance, clamped to the symmetric limit).
// ---------------------------------------------------------------------------
`include "balance_position_pid_macros.svh"

module bpp_combine
  import bpp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  prod_t      data_i,
  bpp_drive_if.source drive_o
);

  localparam logic signed [BSUM_W-1:0] BAL_RND = BSUM_W'({BAL_FRAC{1'b1}});
  localparam logic signed [PSUM_W-1:0] POS_RND = PSUM_W'({POS_FRAC{1'b1}});

  // Sum stage
  logic                      sum_valid_q;
  logic                      sum_ready;
  logic signed [BAL_W-1:0]   bal_q;
  logic signed [POS_W-1:0]   pos_q;
  logic signed [PERR_W-1:0]  sum_perr_q;
  logic signed [BSUM_W-1:0]  bal_sum, bal_adj;
  logic signed [PSUM_W-1:0]  pos_sum, pos_adj;

  // Output stage
  logic                      out_valid_q;
  logic                      out_ready;
  logic signed [DRIVE_W-1:0] drive_q;
  logic signed [PERR_W-1:0]  out_perr_q;
  logic                      clamped_q;
  logic signed [DRV_W-1:0]   drive;
  logic signed [DRV_W-1:0]   lim;
  logic signed [DRIVE_W-1:0] lim_s;
  logic signed [DRIVE_W-1:0] drive_d;
  logic                      clip;

  assign out_ready = !out_valid_q || drive_o.ready;
  assign sum_ready = !sum_valid_q || out_ready;
  assign ready_o   = sum_ready;

  // Add each loop's products and drop fraction bits toward zero
  always_comb begin
    bal_sum = BSUM_W'($signed(data_i.bal_p)) + BSUM_W'($signed(data_i.bal_i))
            + BSUM_W'($signed(data_i.bal_d));
    bal_adj = bal_sum[BSUM_W-1] ? bal_sum + BAL_RND : bal_sum;
    pos_sum = PSUM_W'($signed(data_i.pos_p)) + PSUM_W'($signed(data_i.pos_d));
    pos_adj = pos_sum[PSUM_W-1] ? pos_sum + POS_RND : pos_sum;
  end

  // Combine the loops and clamp
  always_comb begin
    drive   = DRV_W'(pos_q) - DRV_W'(bal_q);
    lim     = $signed(DRV_W'(cfg_i.output_limit));
    lim_s   = $signed(DRIVE_W'(cfg_i.output_limit));
    clip    = 1'b0;
    drive_d = drive[DRIVE_W-1:0];
    if (drive > lim) begin
      drive_d = lim_s;
      clip    = 1'b1;
    end else if (drive < -lim) begin
      drive_d = -lim_s;
      clip    = 1'b1;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid_q <= valid_i;
      end
      if (out_ready) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  // Capture stage payloads
  always_ff @(posedge clk_i) begin
    if (valid_i && sum_ready) begin
      bal_q      <= bal_adj[BSUM_W-1:BAL_FRAC];
      pos_q      <= pos_adj[PSUM_W-1:POS_FRAC];
      sum_perr_q <= $signed(data_i.perr);
    end
    if (sum_valid_q && out_ready) begin
      drive_q    <= drive_d;
      out_perr_q <= sum_perr_q;
      clamped_q  <= clip;
    end
  end

  assign drive_o.valid          = out_valid_q;
  assign drive_o.motor_drive    = drive_q;
  assign drive_o.position_error = out_perr_q;
  assign drive_o.clamped        = clamped_q;

  `BPP_ASSERT(a_clamp_at_limit, clk_i, rst_ni, out_valid_q && clamped_q |-> (drive_q == lim_s) || (drive_q == -lim_s))
  `BPP_ASSERT(a_within_limit, clk_i, rst_ni, out_valid_q && !clamped_q |-> (drive_q <= lim_s) && (drive_q >= -lim_s))

endmodule
